[design/bpid_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package bpid_pkg;
  localparam int NumRegs = 7;
  localparam int CfgIdxW = 3;
  localparam int DutyMaxDefault = 65535;
  localparam int ProdW = 50;
  localparam int BlendW = 54;
  localparam logic [CfgIdxW-1:0] RegAngleKp = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAngleKi = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAngleKd = 3'd2;
  localparam logic [CfgIdxW-1:0] RegSpeedKp = 3'd3;
  localparam logic [CfgIdxW-1:0] RegSpeedKi = 3'd4;
  localparam logic [CfgIdxW-1:0] RegAngleLim = 3'd5;
  localparam logic [CfgIdxW-1:0] RegSpeedLim = 3'd6;

  typedef struct packed {
    logic start;
    logic signed [15:0] gain;
    logic signed [33:0] mcand;
  } mul_req_t;
endpackage
`default_nettype wire

[design/bpid_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
module bpid_serial_mul (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire bpid_pkg::mul_req_t            req,
  output logic                               done,
  output logic signed [bpid_pkg::ProdW-1:0]  prod
);
  import bpid_pkg::*;

  logic [15:0]              gain_r, gain_nxt;
  logic signed [ProdW-1:0]  acc_r, acc_nxt;
  logic signed [ProdW-1:0]  mc_r, mc_nxt;
  logic [4:0]               cnt_r, cnt_nxt;
  logic                     busy_r, busy_nxt;
  logic                     done_r, done_nxt;

  always_comb begin
    gain_nxt = gain_r;
    acc_nxt  = acc_r;
    mc_nxt   = mc_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      gain_nxt = req.gain;
      mc_nxt   = ProdW'(req.mcand);
      acc_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (gain_r[0]) begin
        if (cnt_r == 5'd15) acc_nxt = acc_r - mc_r;
        else acc_nxt = acc_r + mc_r;
      end
      mc_nxt   = mc_r <<< 1;
      gain_nxt = gain_r >> 1;
      cnt_nxt  = cnt_r + 5'd1;
      if (cnt_r == 5'd15) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    gain_r <= gain_nxt;
    acc_r  <= acc_nxt;
    mc_r   <= mc_nxt;
  end

  assign done = done_r;
  assign prod = acc_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("done held");
  a_busy_done: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |=> !busy_r || $past(req.start))
    else $error("spurious start");
endmodule
`default_nettype wire

[design/bpid_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none
module bpid_serial_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  input  wire logic [bpid_pkg::BlendW-1:0]   dividend,
  output logic                               done,
  output logic [bpid_pkg::BlendW-1:0]        quot
);
  import bpid_pkg::*;

  localparam logic [10:0] Divisor = 11'd1280;

  logic [BlendW-1:0] q_r, q_nxt;
  logic [10:0]       rem_r, rem_nxt;
  logic [5:0]        cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [11:0]       trial;

  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, q_r[BlendW-1]};
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, Divisor}) begin
        rem_nxt = 11'(trial - {1'b0, Divisor});
        q_nxt   = {q_r[BlendW-2:0], 1'b1};
      end else begin
        rem_nxt = trial[10:0];
        q_nxt   = {q_r[BlendW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'(BlendW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n) done_r |=> !done_r)
    else $error("done held");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rem_r < Divisor)
    else $error("remainder out of range");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("done while busy");
endmodule
`default_nettype wire

[design/blended_pid_pi_motor_controller_core.sv]
// Blended angle PID / speed PI duty controller.
// Input channel in_*: one transaction per sample; in_tdata packs angle_meas,
// first_angle_target, second_angle_target, speed_meas, speed_goal (16 bits
// each, lowest first). Output channel out_*: one transaction per sample with
// duty, angle_error, speed_error, first_settled, stop_motor.
// Gains and settle limits are to be written on cfg_* while the block is idle;
// the user must keep to this, as the block itself does not enforce it. Each
// update runs five products on one bit-serial 16-step multiplier and then a
// radix-2 divide by 1280. The result is written after the last update (the
// second one when it runs), and the next sample is taken after that. One
// sample is processed at a time.
// The result sits in an output register; a new sample is accepted while it
// waits, and processing stalls before writing the next result until the
// receiver takes the old one.
// Reset clears gains and limits to defaults and the controller state to zero.
`timescale 1ns / 1ps
`default_nettype none
module blended_pid_pi_motor_controller_core #(
  parameter int DUTY_MAX = bpid_pkg::DutyMaxDefault
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // angle_meas, first_angle_target, second_angle_target, speed_meas, speed_goal
  input  wire logic [79:0]                    in_tdata,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // duty, angle_error, speed_error, first_settled, stop_motor, zero fill
  output logic [55:0]                         out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [bpid_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [15:0]                    cfg_wdata
);
  import bpid_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_ERR   = 9'b000000010,
    S_MUL   = 9'b000000100,
    S_MWAIT = 9'b000001000,
    S_BLEND = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_DWAIT = 9'b001000000,
    S_CHECK = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  localparam logic signed [33:0] S32Max = 34'sd2147483647;
  localparam logic signed [33:0] S32Min = -34'sd2147483648;

  state_t state_r, state_nxt;
  logic signed [15:0] kp_a_r, ki_a_r, kd_a_r, kp_s_r, ki_s_r, lim_a_r, lim_s_r;
  logic [79:0] smp_r, smp_nxt;
  logic signed [31:0] integ_r, integ_nxt, accum_r, accum_nxt;
  logic signed [16:0] pea_r, pea_nxt, pes_r, pes_nxt;
  logic signed [16:0] ea_r, ea_nxt, es_r, es_nxt;
  logic signed [ProdW-1:0] pid_r, pid_nxt, pi_r, pi_nxt;
  logic [2:0] op_r, op_nxt;
  logic second_r, second_nxt, first_r, first_nxt, stop_r, stop_nxt;
  logic [15:0] duty_r, duty_nxt;
  logic [BlendW-1:0] blend_r, blend_nxt;
  logic [55:0] obuf_r, obuf_nxt;
  logic ovalid_r, ovalid_nxt;

  mul_req_t mreq;
  logic mdone, dstart, ddone;
  logic signed [ProdW-1:0] mprod;
  logic [BlendW-1:0] dquot;
  logic signed [16:0] tgt;
  logic signed [33:0] isum, asum;
  logic settled;
  logic in_acc;

  bpid_serial_mul u_mul (.clk, .rst_n, .req(mreq), .done(mdone), .prod(mprod));
  bpid_serial_div u_div (.clk, .rst_n, .start(dstart), .dividend(blend_r),
                         .done(ddone), .quot(dquot));

  assign in_tready = state_r == S_IDLE;
  assign in_acc = in_tvalid && in_tready;
  assign tgt = second_r ? 17'(signed'(smp_r[47:32])) : 17'(signed'(smp_r[31:16]));
  assign isum = 34'(integ_r) + 34'(ea_r);
  assign asum = 34'(accum_r) + 34'(signed'(pi_r[33:0]));
  assign settled = (ea_r < 17'(lim_a_r)) && (es_r < 17'(lim_s_r));

  always_comb begin
    mreq.start = 1'b0;
    mreq.gain  = kp_a_r;
    mreq.mcand = 34'(ea_r);
    case (op_r)
      3'd0: begin mreq.gain = kp_a_r; mreq.mcand = 34'(ea_r); end
      3'd1: begin mreq.gain = ki_a_r; mreq.mcand = 34'(integ_r); end
      3'd2: begin mreq.gain = kd_a_r; mreq.mcand = 34'(ea_r) - 34'(pea_r); end
      3'd3: begin mreq.gain = kp_s_r; mreq.mcand = 34'(es_r) - 34'(pes_r); end
      default: begin mreq.gain = ki_s_r; mreq.mcand = 34'(es_r); end
    endcase
    mreq.start = state_r == S_MUL;
  end

  always_comb begin
    state_nxt = state_r;
    smp_nxt = smp_r; integ_nxt = integ_r; accum_nxt = accum_r;
    pea_nxt = pea_r; pes_nxt = pes_r; ea_nxt = ea_r; es_nxt = es_r;
    pid_nxt = pid_r; pi_nxt = pi_r; op_nxt = op_r;
    second_nxt = second_r; first_nxt = first_r; stop_nxt = stop_r;
    duty_nxt = duty_r; blend_nxt = blend_r;
    obuf_nxt = obuf_r; ovalid_nxt = ovalid_r;
    dstart = 1'b0;
    if (out_tvalid && out_tready) ovalid_nxt = 1'b0;
    case (state_r)
      S_IDLE: if (in_acc) begin
        smp_nxt = in_tdata;
        second_nxt = 1'b0; first_nxt = 1'b0; stop_nxt = 1'b0;
        state_nxt = S_ERR;
      end
      S_ERR: begin
        ea_nxt = 17'(signed'(smp_r[15:0])) - tgt;
        es_nxt = 17'(signed'(smp_r[63:48])) - 17'(signed'(smp_r[79:64]));
        pid_nxt = '0; pi_nxt = '0; op_nxt = 3'd0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        if (op_r == 3'd0) begin
          if (isum > S32Max) integ_nxt = S32Max[31:0];
          else if (isum < S32Min) integ_nxt = S32Min[31:0];
          else integ_nxt = isum[31:0];
        end
        state_nxt = S_MWAIT;
      end
      S_MWAIT: if (mdone) begin
        if (op_r <= 3'd2) pid_nxt = pid_r + mprod;
        else pi_nxt = pi_r + mprod;
        if (op_r == 3'd4) state_nxt = S_BLEND;
        else begin op_nxt = op_r + 3'd1; state_nxt = S_MUL; end
      end
      S_BLEND: begin
        if (asum > S32Max) accum_nxt = S32Max[31:0];
        else if (asum < S32Min) accum_nxt = S32Min[31:0];
        else accum_nxt = asum[31:0];
        pea_nxt = ea_r; pes_nxt = es_r;
        blend_nxt = BlendW'(3 * BlendW'(pid_r)) + BlendW'(signed'({accum_nxt, 1'b0}));
        state_nxt = S_DIV;
      end
      S_DIV: begin
        dstart = 1'b1;
        state_nxt = S_DWAIT;
      end
      S_DWAIT: if (ddone) begin
        if (blend_r[BlendW-1] || blend_r == '0) duty_nxt = '0;
        else if (dquot > BlendW'(DUTY_MAX)) duty_nxt = 16'(DUTY_MAX);
        else duty_nxt = dquot[15:0];
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (settled && !second_r) begin
          first_nxt = 1'b1; second_nxt = 1'b1; state_nxt = S_ERR;
        end else begin
          if (settled) begin stop_nxt = 1'b1; duty_nxt = '0; end
          state_nxt = S_OUT;
        end
      end
      S_OUT: if (!ovalid_nxt) begin
        obuf_nxt = {4'd0, stop_r, first_r, es_r, ea_r, duty_r};
        ovalid_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ovalid_r <= 1'b0;
      kp_a_r <= 16'sd256; ki_a_r <= '0; kd_a_r <= '0;
      kp_s_r <= 16'sd256; ki_s_r <= '0; lim_a_r <= 16'sd2; lim_s_r <= 16'sd78;
      integ_r <= '0; accum_r <= '0; pea_r <= '0; pes_r <= '0;
    end else begin
      state_r <= state_nxt;
      ovalid_r <= ovalid_nxt;
      integ_r <= integ_nxt; accum_r <= accum_nxt;
      pea_r <= pea_nxt; pes_r <= pes_nxt;
      if (cfg_we) begin
        case (cfg_index)
          RegAngleKp:  kp_a_r <= cfg_wdata;
          RegAngleKi:  ki_a_r <= cfg_wdata;
          RegAngleKd:  kd_a_r <= cfg_wdata;
          RegSpeedKp:  kp_s_r <= cfg_wdata;
          RegSpeedKi:  ki_s_r <= cfg_wdata;
          RegAngleLim: lim_a_r <= cfg_wdata;
          RegSpeedLim: lim_s_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
    smp_r <= smp_nxt; ea_r <= ea_nxt; es_r <= es_nxt;
    pid_r <= pid_nxt; pi_r <= pi_nxt; op_r <= op_nxt;
    second_r <= second_nxt; first_r <= first_nxt; stop_r <= stop_nxt;
    duty_r <= duty_nxt; blend_r <= blend_nxt; obuf_r <= obuf_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = obuf_r;

  a_stop_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !out_tdata[51] || out_tdata[50])
    else $error("stop without first settle");
  a_stop_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[51] |-> out_tdata[15:0] == '0)
    else $error("duty nonzero on stop");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped");
endmodule
`default_nettype wire

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import bpid_pkg::*;

  localparam logic [CfgIdxW-1:0] RegUnused = 3'd7;
  localparam longint DutyCeil = 65535;
  localparam int CycleLimit = 3000000;

  typedef struct packed {
    logic [15:0] goal;
    logic [15:0] speed;
    logic [15:0] target2;
    logic [15:0] target1;
    logic [15:0] angle;
  } sample_t;

  typedef struct packed {
    logic [3:0]  fill;
    logic        stop;
    logic        first;
    logic [16:0] speed_err;
    logic [16:0] angle_err;
    logic [15:0] duty;
  } duty_result_t;

  class duty_scoreboard;
    longint gain[NumRegs];
    longint integ, prev_ea, prev_es, accum;
    duty_result_t pending[$];
    int errors;

    function new();
      gain = '{256, 0, 0, 256, 0, 2, 78};
      integ = 0; prev_ea = 0; prev_es = 0; accum = 0; errors = 0;
    endfunction

    function void set_gain(logic [CfgIdxW-1:0] idx, logic [15:0] val);
      if (idx < NumRegs) gain[idx] = longint'($signed(val));
    endfunction

    function longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
    endfunction

    function void control_update(longint ang, longint tgt, longint spd, longint goal,
                                 output longint ea, output longint es,
                                 output longint duty);
      longint pid, blend;
      ea = ang - tgt;
      es = spd - goal;
      integ = clamp32(integ + ea);
      pid = gain[RegAngleKp] * ea + gain[RegAngleKi] * integ
          + gain[RegAngleKd] * (ea - prev_ea);
      accum = clamp32(accum + gain[RegSpeedKp] * (es - prev_es) + gain[RegSpeedKi] * es);
      prev_ea = ea;
      prev_es = es;
      blend = 3 * pid + 2 * accum;
      if (blend <= 0) duty = 0;
      else begin
        duty = blend / 1280;
        if (duty > DutyCeil) duty = DutyCeil;
      end
    endfunction

    function void note_input(sample_t s);
      longint ea, es, duty;
      duty_result_t r;
      r = '0;
      control_update($signed(s.angle), $signed(s.target1), $signed(s.speed),
                     $signed(s.goal), ea, es, duty);
      if (ea < gain[RegAngleLim] && es < gain[RegSpeedLim]) begin
        r.first = 1'b1;
        control_update($signed(s.angle), $signed(s.target2), $signed(s.speed),
                       $signed(s.goal), ea, es, duty);
        if (ea < gain[RegAngleLim] && es < gain[RegSpeedLim]) begin
          r.stop = 1'b1;
          duty = 0;
        end
      end
      r.duty = duty[15:0];
      r.angle_err = ea[16:0];
      r.speed_err = es[16:0];
      pending.push_back(r);
    endfunction

    function void check(logic [55:0] data);
      duty_result_t got, exp_r;
      got = data;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, data);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.duty !== exp_r.duty) begin
        $display("%0t: duty exp %0d got %0d", $time, exp_r.duty, got.duty);
        errors++;
      end
      if (got.angle_err !== exp_r.angle_err) begin
        $display("%0t: angle_error exp %h got %h", $time, exp_r.angle_err, got.angle_err);
        errors++;
      end
      if (got.speed_err !== exp_r.speed_err) begin
        $display("%0t: speed_error exp %h got %h", $time, exp_r.speed_err, got.speed_err);
        errors++;
      end
      if (got.first !== exp_r.first) begin
        $display("%0t: first_settled exp %b got %b", $time, exp_r.first, got.first);
        errors++;
      end
      if (got.stop !== exp_r.stop) begin
        $display("%0t: stop_motor exp %b got %b", $time, exp_r.stop, got.stop);
        errors++;
      end
      if (got.fill !== 4'b0) begin
        $display("%0t: fill exp 0 got %h", $time, got.fill);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [79:0] in_tdata = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  duty_scoreboard sb = new();
  bit quiet = 1'b0;
  int hold_req = 0;
  int hold_left = 0;
  int burst = 0;
  int cycles = 0;

  blended_pid_pi_motor_controller_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("testbench failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check(out_tdata);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (!rst_n) out_tready <= 1'b0;
    else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (burst > 0) begin
      burst--;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(1, 12) - 1;
      out_tready <= 1'b0;
    end else out_tready <= 1'b1;
  end

  task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_gain(idx, val);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic send(sample_t s);
    in_tvalid <= 1'b1;
    in_tdata <= s;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_input(s);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  task automatic drain();
    @(posedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  function automatic logic [15:0] near(logic [15:0] base, int span);
    return base + 16'($urandom_range(0, 2 * span)) - 16'(span);
  endfunction

  function automatic sample_t random_sample();
    sample_t s;
    s = 80'($urandom()) ^ 80'({$urandom(), $urandom(), $urandom()});
    case ($urandom_range(0, 3))
      0: ;
      1: begin
        s.target1 = near(s.angle, 4);
        s.target2 = near(s.angle, 4);
        s.goal = near(s.speed, 100);
      end
      2: begin
        s.target1 = near(s.angle, 3);
        s.goal = near(s.speed, 80);
      end
      default: begin
        s.angle = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        s.speed = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
        s.target1 = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      end
    endcase
    return s;
  endfunction

  task automatic set_gains(logic [15:0] akp, logic [15:0] aki, logic [15:0] akd,
                           logic [15:0] skp, logic [15:0] ski,
                           logic [15:0] alim, logic [15:0] slim);
    cfg_write(RegAngleKp, akp);
    cfg_write(RegAngleKi, aki);
    cfg_write(RegAngleKd, akd);
    cfg_write(RegSpeedKp, skp);
    cfg_write(RegSpeedKi, ski);
    cfg_write(RegAngleLim, alim);
    cfg_write(RegSpeedLim, slim);
  endtask

  initial begin
    sample_t s;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send({16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000});
    send({16'h8000, 16'h7fff, 16'h0000, 16'h8000, 16'h7fff});
    send({16'h7fff, 16'h8000, 16'h0000, 16'h7fff, 16'h8000});
    send({16'h0000, 16'h0064, 16'h0000, 16'h0005, 16'h0000});
    send({16'h0000, 16'h0000, 16'h0010, 16'h0000, 16'h0000});
    send({16'h0000, 16'h0000, 16'hfff0, 16'h0003, 16'h0000});
    send({16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff});
    send({16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000});
    send({16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff});
    send({16'h0000, 16'h004d, 16'h0000, 16'h0002, 16'h0000});
    drain();
    cfg_write(RegUnused, 16'h1234);
    set_gains(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    repeat (6) send({16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff});
    repeat (6) send({16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000});
    drain();
    set_gains(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
    repeat (6) send({16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 16'h8000});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: set_gains(16'd256, 16'd0, 16'd0, 16'd256, 16'd0, 16'd2, 16'd78);
        1, 4: set_gains(16'($urandom()), 16'($urandom()), 16'($urandom()),
                        16'($urandom()), 16'($urandom()),
                        16'($urandom_range(0, 8)), 16'($urandom_range(0, 200)));
        2: set_gains(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000);
        3: set_gains(16'd400, 16'd20, 16'd100, 16'd300, 16'd30, 16'd3, 16'd90);
        5: set_gains(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h0, 16'h0);
        6: set_gains(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 63)),
                     16'($urandom_range(0, 255)), 16'($urandom_range(0, 1023)),
                     16'($urandom_range(0, 63)), 16'd4, 16'd100);
        default: begin
          set_gains(16'd256, 16'd5, 16'd64, 16'd256, 16'd10, 16'd2, 16'd78);
          quiet = 1'b1;
        end
      endcase
      if (ph == 2) hold_req = 3000;
      for (int i = 0; i < 220; i++) begin
        if (ph == 3 && i == 110) begin
          @(posedge clk);
          in_tvalid <= 1'b0;
          while (sb.pending.size() > 0) @(posedge clk);
        end
        s = random_sample();
        send(s);
      end
      drain();
    end

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end
endmodule
